// ----- hdl/bfa_pkg.sv -----
// Shared types, constants and helper functions of the buddy frame allocator.
// Used by bfa_front, bfa_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

  localparam int FRAME_INDEX_BITS = 10;
  localparam int TOP_ORDER        = 10;
  localparam int POOL_MAX         = 1 << FRAME_INDEX_BITS;
  localparam int MAX_BLOCK        = 1 << TOP_ORDER;
  localparam int IDX_W            = FRAME_INDEX_BITS + 1;
  localparam int CNT_W            = 11;
  localparam int ORDER_W          = $clog2(TOP_ORDER + 1);

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_RESV  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_CONFLICT = 2'd3;

  localparam logic [1:0] FS_FREE  = 2'd0;
  localparam logic [1:0] FS_ALLOC = 2'd1;
  localparam logic [1:0] FS_RESV  = 2'd2;

  typedef enum logic [2:0] {
    K_INIT, K_NOP, K_TOOBIG, K_RANGE, K_ALLOC, K_FREE, K_RESV
  } kind_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  frame_number;
    logic [10:0] frame_count;
  } cmd_t;

  typedef struct packed {
    logic [9:0] first_frame;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    kind_e                  kind;
    logic [9:0]             fn;
    logic [CNT_W-1:0]       cnt;
    logic [ORDER_W-1:0]     k;
    logic [IDX_W-1:0]       end_f;
  } job_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               head;
    logic [ORDER_W-1:0] order;
  } frame_word_t;

  localparam int WORD_W = $bits(frame_word_t);

  // largest order o with p aligned to 2^o and p + 2^o <= e
  function automatic logic [ORDER_W-1:0] span_order(input logic [IDX_W-1:0] p,
                                                    input logic [IDX_W-1:0] e);
    logic               ok;
    logic [ORDER_W-1:0] r;
    logic [IDX_W:0]     s;
    ok = 1'b1;
    r  = '0;
    for (int o = 1; o <= TOP_ORDER; o++) begin
      s  = (IDX_W+1)'(1) << o;
      ok = ok && (({1'b0, p} & (s - (IDX_W+1)'(1))) == '0) && (({1'b0, p} + s) <= {1'b0, e});
      if (ok) r = ORDER_W'(o);
    end
    return r;
  endfunction

  // smallest order whose block holds c frames
  function automatic logic [ORDER_W-1:0] ceil_order(input logic [CNT_W-1:0] c);
    logic [ORDER_W-1:0] r;
    r = ORDER_W'(TOP_ORDER);
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if (32'(c) <= (32'd1 << o)) r = ORDER_W'(o);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/bfa_front.sv -----
// Front end: classifies incoming command words and queues them for the back end.
// Depends on bfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfa_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire bfa_pkg::cmd_t           cmd_i,
  input  wire logic [bfa_pkg::IDX_W-1:0] pool_i,
  input  wire bfa_pkg::back_ctl_t      ctl_i,
  output logic                         busy_o,
  output logic                         job_valid_o,
  output bfa_pkg::job_t                job_o
);
  import bfa_pkg::*;

  job_t         mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  job_t         job;
  logic [IDX_W:0] end_w;
  logic         push;

  always_comb begin
    end_w       = (IDX_W+1)'(cmd_i.frame_number) + (IDX_W+1)'(cmd_i.frame_count);
    job.fn      = cmd_i.frame_number;
    job.cnt     = cmd_i.frame_count;
    job.k       = ceil_order(cmd_i.frame_count);
    job.end_f   = end_w[IDX_W-1:0];
    if (cmd_i.opcode == OP_INIT) begin
      job.kind = K_INIT;
    end else if (cmd_i.frame_count == '0) begin
      job.kind = K_NOP;
    end else if (cmd_i.opcode == OP_ALLOC) begin
      job.kind = (32'(cmd_i.frame_count) > MAX_BLOCK) ? K_TOOBIG : K_ALLOC;
    end else if (end_w > {1'b0, pool_i}) begin
      job.kind = K_RANGE;
    end else if (cmd_i.opcode == OP_FREE) begin
      job.kind = K_FREE;
    end else begin
      job.kind = K_RESV;
    end
  end

  assign busy_o      = (cnt_q == 2'd2) || ctl_i.clearing;
  assign push        = start_i && !busy_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        mem_q[wp_q] <= job;
        wp_q        <= !wp_q;
      end
      if (ctl_i.pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(ctl_i.pop);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bfa_back.sv -----
// Back end: sequencer that walks the frame table to initialize, allocate, free and reserve.
// Depends on bfa_pkg and bfa_ram.
`timescale 1ns / 1ps
`default_nettype none
module bfa_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      job_valid_i,
  input  wire bfa_pkg::job_t             job_i,
  input  wire logic [bfa_pkg::IDX_W-1:0] pool_i,
  output bfa_pkg::back_ctl_t             ctl_o,
  output logic                           done_o,
  output bfa_pkg::result_t               result_o
);
  import bfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_ARD, S_AEV, S_CRD, S_CEV, S_FSET, S_PIECE,
    S_MRD, S_MEV, S_MHEAD, S_RRD, S_REV
  } state_e;

  typedef enum logic [1:0] { M_SPAN, M_ALLOC, M_RESV } mode_e;

  localparam logic [IDX_W-1:0] POOL_END = IDX_W'(POOL_MAX);

  state_e             state_q, state_d;
  logic               clr_q, clr_d;
  job_t               op_q, op_d;
  logic [IDX_W-1:0]   idx_q, idx_d, wi_q, wi_d, wnext_q, wnext_d;
  logic [IDX_W-1:0]   wa_q, wa_d, wc_q, wc_d, wd_q, wd_d, wb_q, wb_d;
  mode_e              wm1_q, wm1_d, wm2_q, wm2_d, wm3_q, wm3_d;
  logic               found_q, found_d, fail_q, fail_d;
  logic [9:0]         best_q, best_d;
  logic [ORDER_W-1:0] bord_q, bord_d, mo_q, mo_d;
  logic [IDX_W-1:0]   mp_q, mp_d, pp_q, pp_d;
  logic               done_q, done_d;
  result_t            res_q, res_d;

  logic               ram_we;
  logic [9:0]         ram_waddr, ram_raddr;
  frame_word_t        ram_wdata, rd;
  logic [WORD_W-1:0]  rdata;

  mode_e              rm;
  logic [IDX_W-1:0]   rs, re, bd, e_blk, lo, hi;
  logic [ORDER_W-1:0] so;
  logic               hd, nf;
  logic [9:0]         nb;
  logic [ORDER_W-1:0] no;

  assign rd = frame_word_t'(rdata);

  bfa_ram #(.WIDTH(WORD_W), .DEPTH(POOL_MAX)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q; clr_d = clr_q; op_d = op_q; idx_d = idx_q; wi_d = wi_q;
    wnext_d = wnext_q; wa_d = wa_q; wc_d = wc_q; wd_d = wd_q; wb_d = wb_q;
    wm1_d = wm1_q; wm2_d = wm2_q; wm3_d = wm3_q; found_d = found_q; fail_d = fail_q;
    best_d = best_q; bord_d = bord_q; mo_d = mo_q; mp_d = mp_q; pp_d = pp_q;
    done_d = 1'b0; res_d = res_q;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    ctl_o.pop = 1'b0;
    ctl_o.clearing = clr_q;
    rm = wm3_q; rs = wd_q; re = wb_q; so = '0; hd = 1'b0;
    bd = mp_q ^ (IDX_W'(1) << mo_q);
    e_blk = idx_q + (IDX_W'(1) << rd.order);
    lo = '0; hi = '0; nf = found_q; nb = best_q; no = bord_q;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i && !clr_q) begin
          ctl_o.pop = 1'b1;
          op_d      = job_i;
          res_d.first_frame = '0;
          case (job_i.kind)
            K_NOP: begin
              done_d = 1'b1; res_d.status = ST_OK;
            end
            K_TOOBIG: begin
              done_d = 1'b1; res_d.status = ST_TOO_BIG;
            end
            K_RANGE: begin
              done_d = 1'b1; res_d.status = ST_CONFLICT;
            end
            K_INIT: begin
              wa_d = '0; wc_d = '0; wd_d = pool_i; wb_d = POOL_END;
              wm1_d = M_RESV; wm2_d = M_SPAN; wm3_d = M_RESV;
              wi_d = '0; wnext_d = '0;
              state_d = S_WR;
            end
            K_ALLOC: begin
              idx_d = '0; found_d = 1'b0; state_d = S_ARD;
            end
            default: begin
              idx_d = IDX_W'(job_i.fn); fail_d = 1'b0; state_d = S_CRD;
            end
          endcase
        end
      end
      S_WR: begin
        if (wi_q >= wb_q) begin
          if (clr_q) begin
            clr_d = 1'b0; state_d = S_IDLE;
          end else if (op_q.kind == K_RESV) begin
            state_d = S_RRD;
          end else begin
            done_d = 1'b1; res_d.status = ST_OK; state_d = S_IDLE;
          end
        end else begin
          if (wi_q < wc_q) begin
            rm = wm1_q; rs = wa_q; re = wc_q;
          end else if (wi_q < wd_q) begin
            rm = wm2_q; rs = wc_q; re = wd_q;
          end
          ram_we    = 1'b1;
          ram_waddr = wi_q[9:0];
          case (rm)
            M_SPAN: begin
              so = span_order(wi_q, re);
              hd = (wi_q == rs) || (wi_q == wnext_q);
              ram_wdata.status = FS_FREE;
              ram_wdata.head   = hd;
              ram_wdata.order  = hd ? so : '0;
              if (hd) wnext_d = wi_q + (IDX_W'(1) << so);
            end
            M_ALLOC: ram_wdata.status = FS_ALLOC;
            default: ram_wdata.status = FS_RESV;
          endcase
          wi_d = wi_q + IDX_W'(1);
        end
      end
      S_ARD: begin
        ram_raddr = idx_q[9:0]; state_d = S_AEV;
      end
      S_AEV: begin
        if (rd.head && rd.order >= op_q.k && (!found_q || rd.order < bord_q)) begin
          nf = 1'b1; nb = idx_q[9:0]; no = rd.order;
        end
        found_d = nf; best_d = nb; bord_d = no;
        idx_d = idx_q + IDX_W'(1);
        state_d = S_ARD;
        if (idx_q == POOL_END - IDX_W'(1)) begin
          if (!nf) begin
            done_d = 1'b1; res_d.status = ST_NO_MEM; state_d = S_IDLE;
          end else begin
            wa_d = IDX_W'(nb); wc_d = IDX_W'(nb) + op_q.cnt;
            wd_d = IDX_W'(nb) + (IDX_W'(1) << no); wb_d = IDX_W'(nb) + (IDX_W'(1) << no);
            wm1_d = M_ALLOC; wm2_d = M_SPAN; wm3_d = M_RESV;
            wi_d = IDX_W'(nb); wnext_d = IDX_W'(nb);
            res_d.first_frame = nb;
            state_d = S_WR;
          end
        end
      end
      S_CRD: begin
        if (idx_q >= op_q.end_f) begin
          if (fail_q) begin
            done_d = 1'b1; res_d.status = ST_CONFLICT; state_d = S_IDLE;
          end else if (op_q.kind == K_FREE) begin
            wi_d = IDX_W'(op_q.fn); state_d = S_FSET;
          end else begin
            idx_d = '0; state_d = S_RRD;
          end
        end else begin
          ram_raddr = idx_q[9:0]; state_d = S_CEV;
        end
      end
      S_CEV: begin
        if (op_q.kind == K_FREE) begin
          if (rd.status != FS_ALLOC) fail_d = 1'b1;
        end else begin
          if (rd.status == FS_ALLOC) fail_d = 1'b1;
        end
        idx_d = idx_q + IDX_W'(1); state_d = S_CRD;
      end
      S_FSET: begin
        if (wi_q >= op_q.end_f) begin
          pp_d = IDX_W'(op_q.fn); state_d = S_PIECE;
        end else begin
          ram_we = 1'b1; ram_waddr = wi_q[9:0];
          ram_wdata.status = FS_FREE;
          wi_d = wi_q + IDX_W'(1);
        end
      end
      S_PIECE: begin
        if (pp_q >= op_q.end_f) begin
          done_d = 1'b1; res_d.status = ST_OK; state_d = S_IDLE;
        end else begin
          so = span_order(pp_q, op_q.end_f);
          mp_d = pp_q; mo_d = so;
          pp_d = pp_q + (IDX_W'(1) << so);
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        if (32'(mo_q) >= TOP_ORDER || bd >= pool_i) begin
          state_d = S_MHEAD;
        end else begin
          ram_raddr = bd[9:0]; state_d = S_MEV;
        end
      end
      S_MEV: begin
        if (rd.head && rd.order == mo_q) begin
          ram_we = 1'b1; ram_waddr = bd[9:0];
          ram_wdata.status = FS_FREE;
          if (bd < mp_q) mp_d = bd;
          mo_d = mo_q + ORDER_W'(1);
          state_d = S_MRD;
        end else begin
          state_d = S_MHEAD;
        end
      end
      S_MHEAD: begin
        ram_we = 1'b1; ram_waddr = mp_q[9:0];
        ram_wdata.status = FS_FREE; ram_wdata.head = 1'b1; ram_wdata.order = mo_q;
        state_d = S_PIECE;
      end
      S_RRD: begin
        if (idx_q >= POOL_END) begin
          done_d = 1'b1; res_d.status = ST_OK; state_d = S_IDLE;
        end else begin
          ram_raddr = idx_q[9:0]; state_d = S_REV;
        end
      end
      S_REV: begin
        lo = (IDX_W'(op_q.fn) > idx_q) ? IDX_W'(op_q.fn) : idx_q;
        hi = (op_q.end_f < e_blk) ? op_q.end_f : e_blk;
        if (rd.head && idx_q < op_q.end_f && e_blk > IDX_W'(op_q.fn)) begin
          wa_d = idx_q; wc_d = lo; wd_d = hi; wb_d = e_blk;
          wm1_d = M_SPAN; wm2_d = M_RESV; wm3_d = M_SPAN;
          wi_d = idx_q; wnext_d = idx_q;
          idx_d = e_blk;
          state_d = S_WR;
        end else begin
          idx_d = idx_q + IDX_W'(1); state_d = S_RRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WR;    clr_q <= 1'b1;   op_q <= '0;     idx_q <= '0;
      wi_q <= '0;         wnext_q <= '0;   wa_q <= '0;     wc_q <= '0;
      wd_q <= '0;         wb_q <= POOL_END;
      wm1_q <= M_RESV;    wm2_q <= M_RESV; wm3_q <= M_RESV;
      found_q <= 1'b0;    fail_q <= 1'b0;  best_q <= '0;   bord_q <= '0;
      mo_q <= '0;         mp_q <= '0;      pp_q <= '0;
      done_q <= 1'b0;     res_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d;  op_q <= op_d;   idx_q <= idx_d;
      wi_q <= wi_d;       wnext_q <= wnext_d; wa_q <= wa_d; wc_q <= wc_d;
      wd_q <= wd_d;       wb_q <= wb_d;
      wm1_q <= wm1_d;     wm2_q <= wm2_d;  wm3_q <= wm3_d;
      found_q <= found_d; fail_q <= fail_d; best_q <= best_d; bord_q <= bord_d;
      mo_q <= mo_d;       mp_q <= mp_d;    pp_q <= pp_d;
      done_q <= done_d;   res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;
endmodule
`default_nettype wire

// ----- hdl/buddy_frame_allocator.sv -----
// Top level of the buddy frame allocator: pool size register, front end and back end.
// Depends on bfa_pkg, bfa_front and bfa_back.
//
// A command word is taken when start is high and busy is low; each command returns
// exactly one result word on result_o, marked by done_o for one cycle, which the
// receiver cannot stall. After reset the frame table is swept once with busy high.
// The frame table is one RAM read or written one frame per access, so each command
// walks it: initialize writes every frame, allocate searches the whole table and then
// writes the chosen block, free and reserve read each checked frame and then do the
// split or merge steps (reserve also scans the whole table). Zero-count, too-large
// and out-of-range commands answer without walking the table.
// Up to two commands queue ahead of the back end.
`timescale 1ns / 1ps
`default_nettype none
module buddy_frame_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bfa_pkg::cmd_t             cmd_i,
  output logic                           done_o,
  output bfa_pkg::result_t               result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bfa_pkg::CNT_W-1:0] cfg_wdata_i
);
  import bfa_pkg::*;

  logic [CNT_W-1:0] total_frames_q;
  logic [IDX_W-1:0] pool;
  back_ctl_t        ctl;
  logic             job_valid;
  job_t             job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_frames_q <= CNT_W'(1024);
    end else if (cfg_we_i) begin
      total_frames_q <= cfg_wdata_i;
    end
  end

  assign pool = (32'(total_frames_q) < POOL_MAX) ? IDX_W'(total_frames_q) : IDX_W'(POOL_MAX);

  bfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .pool_i      (pool),
    .ctl_i       (ctl),
    .busy_o      (busy),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  bfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .pool_i      (pool),
    .ctl_o       (ctl),
    .done_o      (done_o),
    .result_o    (result_o)
  );
endmodule
`default_nettype wire
